// ===== src/lpe_pkg.sv =====
// Shared types, constants and the tangent table for the LED pixel PWM encoder.
package lpe_pkg;

	localparam int BitsPerPixel  = 24;
	localparam int MaxBrightness = 45;
	localparam int TanW          = 17;

	typedef enum logic [1:0] {
		CFG_SCALE_ENABLE = 2'd0,
		CFG_ONE_CODE     = 2'd1,
		CFG_ZERO_CODE    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic       scale_enable;
		logic [7:0] one_code;
		logic [7:0] zero_code;
	} cfg_t;

	// handoff from the input stage to the serializer
	typedef struct packed {
		logic                    gap;
		logic [BitsPerPixel-1:0] word;
	} load_t;

	// round(tan(d deg) * 65536), Q1.16
	function automatic logic [TanW-1:0] tan_q16(input logic [5:0] deg);
		logic [TanW-1:0] t;
		case (deg)
			6'd0:  t = 17'd0;
			6'd1:  t = 17'd1144;
			6'd2:  t = 17'd2289;
			6'd3:  t = 17'd3435;
			6'd4:  t = 17'd4583;
			6'd5:  t = 17'd5734;
			6'd6:  t = 17'd6888;
			6'd7:  t = 17'd8047;
			6'd8:  t = 17'd9210;
			6'd9:  t = 17'd10380;
			6'd10: t = 17'd11556;
			6'd11: t = 17'd12739;
			6'd12: t = 17'd13930;
			6'd13: t = 17'd15130;
			6'd14: t = 17'd16340;
			6'd15: t = 17'd17560;
			6'd16: t = 17'd18792;
			6'd17: t = 17'd20036;
			6'd18: t = 17'd21294;
			6'd19: t = 17'd22566;
			6'd20: t = 17'd23853;
			6'd21: t = 17'd25157;
			6'd22: t = 17'd26478;
			6'd23: t = 17'd27818;
			6'd24: t = 17'd29179;
			6'd25: t = 17'd30560;
			6'd26: t = 17'd31964;
			6'd27: t = 17'd33392;
			6'd28: t = 17'd34846;
			6'd29: t = 17'd36327;
			6'd30: t = 17'd37837;
			6'd31: t = 17'd39378;
			6'd32: t = 17'd40951;
			6'd33: t = 17'd42560;
			6'd34: t = 17'd44205;
			6'd35: t = 17'd45889;
			6'd36: t = 17'd47615;
			6'd37: t = 17'd49385;
			6'd38: t = 17'd51202;
			6'd39: t = 17'd53070;
			6'd40: t = 17'd54991;
			6'd41: t = 17'd56970;
			6'd42: t = 17'd59009;
			6'd43: t = 17'd61113;
			6'd44: t = 17'd63287;
			6'd45: t = 17'd65536;
			default: t = 17'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== src/lpe_scale.sv =====
// Brightness scaling of the three channels, when enabled, and GRB packing.
module lpe_scale (
	input  logic                            scale_enable,
	input  logic [7:0]                      red,
	input  logic [7:0]                      green,
	input  logic [7:0]                      blue,
	input  logic [7:0]                      brightness,
	output logic [lpe_pkg::BitsPerPixel-1:0] word
);

	logic [5:0]                 angle;
	logic [lpe_pkg::TanW-1:0]   tan_val;
	logic [24:0]                prod_r;
	logic [24:0]                prod_g;
	logic [24:0]                prod_b;

	always_comb begin
		if (brightness > 8'(lpe_pkg::MaxBrightness)) begin
			angle = 6'(lpe_pkg::MaxBrightness);
		end else begin
			angle = brightness[5:0];
		end
	end

	assign tan_val = lpe_pkg::tan_q16(angle);
	assign prod_r  = 25'(red)   * 25'(tan_val);
	assign prod_g  = 25'(green) * 25'(tan_val);
	assign prod_b  = 25'(blue)  * 25'(tan_val);

	always_comb begin
		if (scale_enable) begin
			word = {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
		end else begin
			word = {green, red, blue};
		end
	end

endmodule

// ===== src/lpe_serializer.sv =====
// Bit serializer: turns a packed pixel or a gap request into duty beats.
module lpe_serializer #(
	parameter int RESET_SLOTS = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_valid,
	output logic          load_ready,
	input  lpe_pkg::load_t load_data,
	input  lpe_pkg::cfg_t  cfg,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    duty,
	output logic          last
);

	localparam int SlotMax = (RESET_SLOTS > lpe_pkg::BitsPerPixel) ?
		RESET_SLOTS : lpe_pkg::BitsPerPixel;
	localparam int CntW = (SlotMax > 1) ? $clog2(SlotMax) : 1;

	logic                            busy_q;
	logic                            gap_q;
	logic [lpe_pkg::BitsPerPixel-1:0] word_q;
	logic [CntW-1:0]                 cnt_q;
	logic                            out_valid_q;
	logic [7:0]                      duty_q;
	logic                            last_q;
	logic                            emit;
	logic                            final_beat;
	logic                            load;

	assign emit       = busy_q && (!out_valid_q || out_ready);
	assign final_beat = (cnt_q == '0);
	assign load_ready = !busy_q || (emit && final_beat);
	assign load       = load_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (emit && final_beat) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gap_q  <= load_data.gap;
			word_q <= load_data.word;
			cnt_q  <= load_data.gap ? CntW'(RESET_SLOTS - 1) :
				CntW'(lpe_pkg::BitsPerPixel - 1);
		end else if (emit) begin
			word_q <= {word_q[lpe_pkg::BitsPerPixel-2:0], 1'b0};
			cnt_q  <= cnt_q - CntW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (gap_q) begin
				duty_q <= '0;
			end else if (word_q[lpe_pkg::BitsPerPixel-1]) begin
				duty_q <= cfg.one_code;
			end else begin
				duty_q <= cfg.zero_code;
			end
			last_q <= final_beat;
		end
	end

	assign out_valid = out_valid_q;
	assign duty      = duty_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q)
		else $error("serializer not busy after load");
	a_gap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && gap_q) |=> (out_valid_q && duty_q == 8'd0))
		else $error("gap beat with nonzero duty");
	a_pixel_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !gap_q) |-> (cnt_q <= CntW'(lpe_pkg::BitsPerPixel - 1)))
		else $error("pixel beat count out of range");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && final_beat && !load) |=> !busy_q)
		else $error("serializer busy after last beat");
`endif

endmodule

// ===== src/led_pixel_pwm_bit_encoder_top.sv =====
// Top level of the LED pixel PWM bit encoder: config, input stage, serializer.
//
// A pixel command produces 24 duty beats (green, red, blue, MSB first), a reset command
// produces RESET_SLOTS beats of duty 0; last marks the final beat of each command. The
// serializer emits one beat per cycle unless out_ready stalls it; the next command waits
// in the input register and is loaded as the previous one's final beat is emitted, giving
// gapless output. An accepted command passes the input and shift registers before its
// first beat is registered. Brightness scaling uses one table lookup and three 8x17
// multiplies. Configuration writes always complete at once and should be made while idle.
module led_pixel_pwm_bit_encoder_top #(
	parameter int RESET_SLOTS = 50
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] brightness,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] duty,
	output logic       last
);

	lpe_pkg::cfg_t  cfg_q;
	logic           valid_s1;
	logic           command_s1;
	logic [7:0]     red_s1;
	logic [7:0]     green_s1;
	logic [7:0]     blue_s1;
	logic [7:0]     brightness_s1;
	logic           load_ready;
	lpe_pkg::load_t load_data;
	logic [lpe_pkg::BitsPerPixel-1:0] word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_enable <= 1'b1;
			cfg_q.one_code     <= 8'd13;
			cfg_q.zero_code    <= 8'd6;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lpe_pkg::CFG_SCALE_ENABLE: cfg_q.scale_enable <= cfg_data[0];
				lpe_pkg::CFG_ONE_CODE:     cfg_q.one_code     <= cfg_data;
				lpe_pkg::CFG_ZERO_CODE:    cfg_q.zero_code    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage frees up when it is empty or as soon as the serializer loads its command
	assign in_ready = !valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1    <= command;
			red_s1        <= red;
			green_s1      <= green;
			blue_s1       <= blue;
			brightness_s1 <= brightness;
		end
	end

	lpe_scale u_scale (
		.scale_enable (cfg_q.scale_enable),
		.red          (red_s1),
		.green        (green_s1),
		.blue         (blue_s1),
		.brightness   (brightness_s1),
		.word         (word)
	);

	assign load_data = {command_s1, word};

	lpe_serializer #(
		.RESET_SLOTS (RESET_SLOTS)
	) u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (load_ready),
		.load_data  (load_data),
		.cfg        (cfg_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duty       (duty),
		.last       (last)
	);

endmodule

// ===== sim/lpe_duty_checker.sv =====
// Watches the encoder's channels, predicts the duty beats of each command and compares them.
module lpe_duty_checker #(
	parameter int GapSlots = 50
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       command,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] brightness,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] duty,
	input  logic       last,
	output int         errors,
	output int         pending,
	output int         beats
);

	localparam logic       ScaleAtReset = 1'b1;
	localparam logic [7:0] OneAtReset   = 8'd13;
	localparam logic [7:0] ZeroAtReset  = 8'd6;

	typedef struct packed {
		logic [7:0] duty;
		logic       last;
	} slot_t;

	slot_t          duty_q[$];
	lpe_pkg::cfg_t  shadow;
	logic [16:0]    tan_lut [46];
	int             err_cnt;
	int             beat_cnt;

	// Q1.16 tangent per whole degree, 0..45
	initial begin
		tan_lut = '{
			17'd0,     17'd1144,  17'd2289,  17'd3435,  17'd4583,  17'd5734,
			17'd6888,  17'd8047,  17'd9210,  17'd10380, 17'd11556, 17'd12739,
			17'd13930, 17'd15130, 17'd16340, 17'd17560, 17'd18792, 17'd20036,
			17'd21294, 17'd22566, 17'd23853, 17'd25157, 17'd26478, 17'd27818,
			17'd29179, 17'd30560, 17'd31964, 17'd33392, 17'd34846, 17'd36327,
			17'd37837, 17'd39378, 17'd40951, 17'd42560, 17'd44205, 17'd45889,
			17'd47615, 17'd49385, 17'd51202, 17'd53070, 17'd54991, 17'd56970,
			17'd59009, 17'd61113, 17'd63287, 17'd65536
		};
	end

	// channel times tan(angle), truncated; angle saturates at the brightness limit
	function automatic logic [7:0] dim_channel(input logic [7:0] chan,
			input logic [7:0] angle);
		logic [5:0]  deg;
		logic [24:0] prod;
		deg  = (angle > lpe_pkg::MaxBrightness) ? 6'(lpe_pkg::MaxBrightness) : angle[5:0];
		prod = chan * tan_lut[deg];
		return prod[23:16];
	endfunction

	task automatic queue_duties(input logic cmd, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] angle);
		logic [lpe_pkg::BitsPerPixel-1:0] grb;
		slot_t                            s;
		if (cmd) begin
			for (int k = 0; k < GapSlots; k++) begin
				s.duty = 8'd0;
				s.last = (k == GapSlots - 1);
				duty_q.push_back(s);
			end
		end else begin
			if (shadow.scale_enable)
				grb = {dim_channel(g, angle), dim_channel(r, angle), dim_channel(b, angle)};
			else
				grb = {g, r, b};
			for (int k = 0; k < lpe_pkg::BitsPerPixel; k++) begin
				s.duty = grb[lpe_pkg::BitsPerPixel-1-k] ? shadow.one_code : shadow.zero_code;
				s.last = (k == lpe_pkg::BitsPerPixel - 1);
				duty_q.push_back(s);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_t exp_slot;
		if (!arst_n) begin
			shadow.scale_enable = ScaleAtReset;
			shadow.one_code     = OneAtReset;
			shadow.zero_code    = ZeroAtReset;
			duty_q.delete();
			err_cnt  = 0;
			beat_cnt = 0;
			errors  <= 0;
			pending <= 0;
			beats   <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lpe_pkg::CFG_SCALE_ENABLE: shadow.scale_enable = cfg_data[0];
					lpe_pkg::CFG_ONE_CODE:     shadow.one_code     = cfg_data;
					lpe_pkg::CFG_ZERO_CODE:    shadow.zero_code    = cfg_data;
					default:                   ;
				endcase
			end
			if (in_valid && in_ready)
				queue_duties(command, red, green, blue, brightness);
			if (out_valid && out_ready) begin
				beat_cnt++;
				if (duty_q.size() == 0) begin
					$error("duty beat %0d / last %0d with nothing outstanding", duty, last);
					err_cnt++;
				end else begin
					exp_slot = duty_q.pop_front();
					if (duty !== exp_slot.duty) begin
						$error("duty: expected %0d, got %0d", exp_slot.duty, duty);
						err_cnt++;
					end
					if (last !== exp_slot.last) begin
						$error("last: expected %0d, got %0d", exp_slot.last, last);
						err_cnt++;
					end
				end
			end
			errors  <= err_cnt;
			pending <= duty_q.size();
			beats   <= beat_cnt;
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the LED pixel PWM encoder: stimulus, backpressure, watchdog and verdict.
module tb_top;

	localparam int         GapSlots      = 50;
	localparam int         IdleLimit     = 1000;
	localparam int         PhaseItems    = 48;
	localparam int         RandomPhases  = 6;
	localparam logic [1:0] CfgOutOfRange = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic       command;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] brightness;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] duty;
	logic       last;

	int errors;
	int pending;
	int beats;
	int n_pixels;
	int n_gaps;
	int n_settings;
	int burst_left;
	int idle_cycles;

	led_pixel_pwm_bit_encoder_top #(
		.RESET_SLOTS(GapSlots)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duty       (duty),
		.last       (last)
	);

	lpe_duty_checker #(
		.GapSlots(GapSlots)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duty       (duty),
		.last       (last),
		.errors     (errors),
		.pending    (pending),
		.beats      (beats)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: runs of ready, mostly ready, coin flips, and long stalls
	always @(posedge clk) begin
		static int stall_mode = 0;
		static int mode_left  = 0;
		static int stall_step = 0;
		if (mode_left == 0) begin
			stall_mode = $urandom_range(3, 0);
			mode_left  = $urandom_range(300, 50);
		end
		mode_left--;
		stall_step++;
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= (stall_step % 4 != 3);
			2:       out_ready <= 1'($urandom_range(1, 0));
			default: out_ready <= (stall_step % 32 < 8);
		endcase
	end

	// no beat on any channel for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IdleLimit) begin
				$display("tb_top: no progress for %0d cycles", IdleLimit);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	task automatic send_cmd(input logic cmd, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] angle);
		int gap;
		in_valid   <= 1'b1;
		command    <= cmd;
		red        <= r;
		green      <= g;
		blue       <= b;
		brightness <= angle;
		do @(posedge clk); while (!in_ready);
		if (cmd) n_gaps++;
		else n_pixels++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			gap        = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 10)
				: $urandom_range(6, 1);
			burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(120, 60)
				: $urandom_range(30, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_cmd();
		logic [7:0] angle;
		angle = ($urandom_range(9, 0) < 7) ? 8'($urandom_range(lpe_pkg::MaxBrightness, 0))
			: 8'($urandom_range(255, 0));
		send_cmd($urandom_range(99, 0) < 12, 8'($urandom), 8'($urandom), 8'($urandom), angle);
	endtask

	// drain everything in flight, then let the output register settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(input logic [7:0] scale, input logic [7:0] one,
			input logic [7:0] zero);
		wait_drained();
		write_reg(lpe_pkg::CFG_SCALE_ENABLE, scale);
		write_reg(lpe_pkg::CFG_ONE_CODE, one);
		write_reg(lpe_pkg::CFG_ZERO_CODE, zero);
		cfg_valid <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		command    = 1'b0;
		red        = '0;
		green      = '0;
		blue       = '0;
		brightness = '0;
		n_pixels   = 0;
		n_gaps     = 0;
		n_settings = 1;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: scaling on, default codes
		send_cmd(1'b0, 8'd0,   8'd0,   8'd0,   8'd0);
		send_cmd(1'b0, 8'd255, 8'd255, 8'd255, 8'd45);
		send_cmd(1'b0, 8'd255, 8'd255, 8'd255, 8'd0);
		send_cmd(1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
		send_cmd(1'b0, 8'd255, 8'd255, 8'd255, 8'd46);
		send_cmd(1'b0, 8'd128, 8'd64,  8'd200, 8'd30);
		send_cmd(1'b1, 8'hA5,  8'h5A,  8'hC3,  8'd77);
		send_cmd(1'b0, 8'hAA,  8'h55,  8'h0F,  8'd45);
		send_cmd(1'b0, 8'd255, 8'd1,   8'd128, 8'd1);
		send_cmd(1'b1, 8'd0,   8'd0,   8'd0,   8'd0);

		// raw channels, extreme codes; only bit 0 of the scale write counts
		apply_setting(8'hFE, 8'd255, 8'd0);
		write_reg(CfgOutOfRange, 8'hFF);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_cmd(1'b0, 8'hAA,  8'h55,  8'hF0,  8'd0);
		send_cmd(1'b0, 8'd255, 8'd255, 8'd255, 8'd200);
		send_cmd(1'b0, 8'd0,   8'd0,   8'd0,   8'd45);
		send_cmd(1'b1, 8'd255, 8'd255, 8'd255, 8'd255);

		apply_setting(8'h01, 8'd0, 8'd255);
		send_cmd(1'b0, 8'h81,  8'h7E,  8'h3C,  8'd45);
		send_cmd(1'b0, 8'd200, 8'd100, 8'd50,  8'd20);
		send_cmd(1'b1, 8'd1,   8'd2,   8'd3,   8'd4);

		for (int p = 0; p < RandomPhases; p++) begin
			if (p == 0)
				apply_setting(8'd1, 8'd13, 8'd6);
			else
				apply_setting(8'($urandom), 8'($urandom), 8'($urandom));
			for (int i = 0; i < PhaseItems; i++)
				send_random_cmd();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("tb_top: %0d pixels and %0d latch gaps over %0d register settings",
			n_pixels, n_gaps, n_settings);
		$display("tb_top: %0d duty beats compared, %0d mismatches", beats, errors);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
